### rtl/core/mpid_pkg.sv
// Shared constants, types and saturation helper for the motor PID speed loop.
package mpid_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int MOTOR_IW    = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    localparam int MIDX_W     = 2;
    localparam int SPEED_W    = 16;
    localparam int GAIN_W     = 8;
    localparam int LIM_W      = 15;
    localparam int MAG_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam int ERR_W  = SPEED_W + 1;   // target minus measured
    localparam int SUM_W  = LIM_W + 1;     // saturated error sum
    localparam int WIDE_W = ERR_W + 1;     // error sum before saturation, error change
    localparam int ACC_W  = 30;            // sum of the three gain products

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_INTEG_LIMIT = 3'd3,
        CFG_DRIVE_LIMIT = 3'd4
    } t_cfg_idx;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 8'd15;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 8'd2;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 8'd8;
    localparam logic [LIM_W-1:0]  INTEG_LIMIT_RST = 15'd1000;
    localparam logic [LIM_W-1:0]  DRIVE_LIMIT_RST = 15'd1000;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [LIM_W-1:0]  integ_limit;
        logic [LIM_W-1:0]  drive_limit;
    } t_cfg;

    typedef struct packed {
        logic [MAG_W-1:0] drive_magnitude;
        logic             bridge_in1;
        logic             bridge_in2;
    } t_result;

    // Saturate a signed value to +/- lim.
    function automatic logic signed [ACC_W-1:0] clamp_sym(
        input logic signed [ACC_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [ACC_W-1:0] res;
        hi = $signed({{(ACC_W-LIM_W){1'b0}}, lim});
        lo = -hi;
        if (v > hi) begin
            res = hi;
        end else if (v < lo) begin
            res = lo;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

### rtl/core/mpid_cfg.sv
// Configuration register bank: gains and saturation limits.
module mpid_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mpid_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mpid_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output mpid_pkg::t_cfg                     o_cfg
);

    mpid_pkg::t_cfg r_cfg;
    mpid_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (mpid_pkg::t_cfg_idx'(i_cfg_idx))
                mpid_pkg::CFG_PROP_GAIN:   n_cfg.prop_gain   = i_cfg_data[mpid_pkg::GAIN_W-1:0];
                mpid_pkg::CFG_INTEG_GAIN:  n_cfg.integ_gain  = i_cfg_data[mpid_pkg::GAIN_W-1:0];
                mpid_pkg::CFG_DERIV_GAIN:  n_cfg.deriv_gain  = i_cfg_data[mpid_pkg::GAIN_W-1:0];
                mpid_pkg::CFG_INTEG_LIMIT: n_cfg.integ_limit = i_cfg_data[mpid_pkg::LIM_W-1:0];
                mpid_pkg::CFG_DRIVE_LIMIT: n_cfg.drive_limit = i_cfg_data[mpid_pkg::LIM_W-1:0];
                default:                   n_cfg = r_cfg;   // drop writes beyond the bank
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= mpid_pkg::PROP_GAIN_RST;
            r_cfg.integ_gain  <= mpid_pkg::INTEG_GAIN_RST;
            r_cfg.deriv_gain  <= mpid_pkg::DERIV_GAIN_RST;
            r_cfg.integ_limit <= mpid_pkg::INTEG_LIMIT_RST;
            r_cfg.drive_limit <= mpid_pkg::DRIVE_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/mpid_core.sv
// PID datapath with per-motor error sum and previous error state.
module mpid_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mpid_pkg::t_cfg                         i_cfg,
    input  logic                                   i_update,
    input  logic [mpid_pkg::MIDX_W-1:0]            i_motor_index,
    input  logic signed [mpid_pkg::SPEED_W-1:0]    i_target_speed,
    input  logic signed [mpid_pkg::SPEED_W-1:0]    i_measured_speed,
    output mpid_pkg::t_result                      o_result
);

    localparam int ACC_W  = mpid_pkg::ACC_W;
    localparam int ERR_W  = mpid_pkg::ERR_W;
    localparam int SUM_W  = mpid_pkg::SUM_W;
    localparam int WIDE_W = mpid_pkg::WIDE_W;
    localparam int GAIN_W = mpid_pkg::GAIN_W;

    logic signed [SUM_W-1:0] r_error_sum      [mpid_pkg::MOTOR_COUNT];
    logic signed [ERR_W-1:0] r_previous_error [mpid_pkg::MOTOR_COUNT];

    logic [mpid_pkg::MOTOR_IW-1:0]  motor_sel;
    logic                           motor_ok;
    logic                           target_zero;
    logic                           active;
    logic signed [SUM_W-1:0]        sum_old;
    logic signed [ERR_W-1:0]        prev_old;
    logic signed [ERR_W-1:0]        err;
    logic signed [WIDE_W-1:0]       sum_raw;
    logic signed [ACC_W-1:0]        sum_sat;
    logic signed [SUM_W-1:0]        sum_new;
    logic signed [WIDE_W-1:0]       err_delta;
    logic signed [GAIN_W:0]         kp;
    logic signed [GAIN_W:0]         ki;
    logic signed [GAIN_W:0]         kd;
    logic signed [GAIN_W+ERR_W:0]   p_term;
    logic signed [GAIN_W+SUM_W:0]   i_term;
    logic signed [GAIN_W+WIDE_W:0]  d_term;
    logic signed [ACC_W-1:0]        drive_raw;
    logic signed [ACC_W-1:0]        drive_sat;
    logic signed [ACC_W-1:0]        drive;
    logic signed [ACC_W-1:0]        drive_abs;

    assign motor_sel   = mpid_pkg::MOTOR_IW'(i_motor_index);
    assign motor_ok    = (32'(i_motor_index) < 32'(mpid_pkg::MOTOR_COUNT));
    assign target_zero = (i_target_speed == '0);
    assign active      = motor_ok && !target_zero;

    assign sum_old  = r_error_sum[motor_sel];
    assign prev_old = r_previous_error[motor_sel];

    assign err = {i_target_speed[mpid_pkg::SPEED_W-1], i_target_speed}
               - {i_measured_speed[mpid_pkg::SPEED_W-1], i_measured_speed};

    assign sum_raw = {{(WIDE_W-SUM_W){sum_old[SUM_W-1]}}, sum_old} + {err[ERR_W-1], err};
    assign sum_sat = mpid_pkg::clamp_sym({{(ACC_W-WIDE_W){sum_raw[WIDE_W-1]}}, sum_raw},
                                         i_cfg.integ_limit);
    assign sum_new = sum_sat[SUM_W-1:0];

    assign err_delta = {err[ERR_W-1], err} - {prev_old[ERR_W-1], prev_old};

    assign kp = $signed({1'b0, i_cfg.prop_gain});
    assign ki = $signed({1'b0, i_cfg.integ_gain});
    assign kd = $signed({1'b0, i_cfg.deriv_gain});

    assign p_term = kp * err;
    assign i_term = ki * sum_new;
    assign d_term = kd * err_delta;

    assign drive_raw = ACC_W'(p_term) + ACC_W'(i_term) + ACC_W'(d_term);
    assign drive_sat = mpid_pkg::clamp_sym(drive_raw, i_cfg.drive_limit);
    assign drive     = active ? drive_sat : '0;
    assign drive_abs = drive[ACC_W-1] ? -drive : drive;

    assign o_result.drive_magnitude = drive_abs[mpid_pkg::MAG_W-1:0];
    assign o_result.bridge_in1      = !drive[ACC_W-1] && (drive != '0);
    assign o_result.bridge_in2      = drive[ACC_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mpid_pkg::MOTOR_COUNT; k++) begin
                r_error_sum[k]      <= '0;
                r_previous_error[k] <= '0;
            end
        end else if (i_update && motor_ok) begin
            // zero target clears the motor's loop
            if (target_zero) begin
                r_error_sum[motor_sel]      <= '0;
                r_previous_error[motor_sel] <= '0;
            end else begin
                r_error_sum[motor_sel]      <= sum_new;
                r_previous_error[motor_sel] <= err;
            end
        end
    end

endmodule

### rtl/core/motor_pid_speed_loop_top.sv
// Top level of the four-motor PID speed loop: handshake registers around the datapath.
//
//  Channel   Direction  Handshake                  Payload
//  in        request    i_in_valid / o_in_ready    i_motor_index, i_target_speed,
//                                                  i_measured_speed
//  out       result     o_out_valid / i_out_ready  o_drive_magnitude, o_bridge_in1,
//                                                  o_bridge_in2, o_echo_motor
//  cfg       write      i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  One request per cycle sustained while results are taken.
//  The request register feeds one pass through the datapath into the result register.
//  Synchronous active-low reset restores the default gains and clears all loop state.
//  A stalled result holds; the request register still takes a request while the
//  result register waits, and ready drops only when both are full.
module motor_pid_speed_loop_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [mpid_pkg::MIDX_W-1:0]            i_motor_index,
    input  logic signed [mpid_pkg::SPEED_W-1:0]    i_target_speed,
    input  logic signed [mpid_pkg::SPEED_W-1:0]    i_measured_speed,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [mpid_pkg::MAG_W-1:0]             o_drive_magnitude,
    output logic                                   o_bridge_in1,
    output logic                                   o_bridge_in2,
    output logic [mpid_pkg::MIDX_W-1:0]            o_echo_motor,
    input  logic                                   i_cfg_we,
    input  logic [mpid_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [mpid_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    mpid_pkg::t_cfg    cfg;
    mpid_pkg::t_result result;

    logic                                 r_in_vld;
    logic [mpid_pkg::MIDX_W-1:0]          r_in_motor;
    logic signed [mpid_pkg::SPEED_W-1:0]  r_in_target;
    logic signed [mpid_pkg::SPEED_W-1:0]  r_in_measured;

    logic                                 r_out_vld;
    mpid_pkg::t_result                    r_out_result;
    logic [mpid_pkg::MIDX_W-1:0]          r_out_motor;

    logic advance;
    logic in_take;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_take    = i_in_valid && o_in_ready;

    mpid_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mpid_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_update         (advance),
        .i_motor_index    (r_in_motor),
        .i_target_speed   (r_in_target),
        .i_measured_speed (r_in_measured),
        .o_result         (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_motor    <= i_motor_index;
            r_in_target   <= i_target_speed;
            r_in_measured <= i_measured_speed;
        end
        if (advance) begin
            r_out_result <= result;
            r_out_motor  <= r_in_motor;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_drive_magnitude = r_out_result.drive_magnitude;
    assign o_bridge_in1      = r_out_result.bridge_in1;
    assign o_bridge_in2      = r_out_result.bridge_in2;
    assign o_echo_motor      = r_out_motor;

endmodule
